@@ hdl/ktau_pkg.sv @@
package ktau_pkg;

    localparam int MAX_N      = 1024;
    localparam int NCELL      = 8;
    localparam int CELL_W     = 3;
    localparam int BANK_DEPTH = MAX_N / NCELL;
    localparam int ADDR_W     = 7;
    localparam int CNT_W      = 11;
    localparam int BLK_W      = 8;
    localparam int KEY_W      = 32;
    localparam int SUM_W      = 21;
    localparam int MAG_W      = 20;
    localparam int NT_W       = 20;
    localparam int FRAC       = 16;
    localparam int TAU_W      = 18;
    localparam int DEN_W      = 2 * NT_W;
    localparam int QUO_W      = 2 * FRAC + 3;
    localparam int NUM_BITS   = DEN_W + 2 * FRAC + 2;
    localparam int NUM_CNT_W  = 7;
    localparam int ROOT_W     = 18;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int SQ_CNT_W   = 5;
    localparam int SREM_W     = ROOT_W + 3;

    typedef enum logic [1:0] {
        TK_CMP  = 2'd0,
        TK_WR   = 2'd1,
        TK_COLL = 2'd2
    } tok_kind_t;

    typedef struct packed {
        logic                     valid;
        tok_kind_t                kind;
        logic [KEY_W-1:0]         x;
        logic [KEY_W-1:0]         y;
        logic [ADDR_W-1:0]        addr;
        logic [CNT_W-1:0]         cnt;
        logic signed [SUM_W-1:0]  sum;
        logic [NT_W-1:0]          cx;
        logic [NT_W-1:0]          cy;
    } tok_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_WRITE,
        ST_COLLECT,
        ST_WAIT,
        ST_MUL,
        ST_TEST,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } state_t;

endpackage

@@ hdl/kendall_tau_b_correlation.sv @@
// Channel   Direction  Signals                        Content
// s_*       input      s_tvalid s_tready s_tdata s_tlast  one (x_key, y_key) pair
// m_*       output     m_tvalid m_tready m_tdata m_tuser  one tau result per set
//
// Each new pair is compared with the pairs already stored: the eight cells of
// the chain each compare one stored pair per cycle. The last pair of a set then
// drains the chain and, unless the result is trivial, the divider and square
// root run before the result transaction is offered.
// Reset clears all control state and counters; the pair stores are not cleared.
// The input stalls while a pair is being processed; the result register holds
// its transaction until m_tready is seen.
module kendall_tau_b_correlation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] x_key, [63:32] y_key
    input  logic        s_tlast,   // last_pair
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [17:0] tau_value, [23:18] zero
    output logic [1:0]  m_tuser    // [0] degenerate, [1] overflow
);

    ktau_pkg::state_t state_reg, state_next;

    logic [ktau_pkg::KEY_W-1:0]  xk_reg, yk_reg;
    logic                        last_reg;
    logic [ktau_pkg::CNT_W-1:0]  cnt_reg;
    logic [ktau_pkg::ADDR_W-1:0] addr_reg;
    logic                        drop_reg;
    logic [ktau_pkg::BLK_W-1:0]  nblk;

    logic signed [ktau_pkg::SUM_W-1:0] sum_reg;
    logic [ktau_pkg::NT_W-1:0]         cx_reg, cy_reg;
    logic [ktau_pkg::MAG_W-1:0]        mag;
    logic [ktau_pkg::DEN_W-1:0]        s2_reg, den_reg;

    logic                        out_valid_reg;
    logic [ktau_pkg::TAU_W-1:0]  tau_reg;
    logic                        degen_reg, ovf_reg;

    logic                        div_start, div_done, sq_start, sq_done;
    logic [ktau_pkg::QUO_W-1:0]  quo;
    logic [ktau_pkg::QUO_W-1:0]  quo_reg;
    logic [ktau_pkg::ROOT_W-1:0] root;
    logic [ktau_pkg::TAU_W-1:0]  qmag;
    logic                        trivial, emit, coll_out;

    ktau_pkg::tok_t link [ktau_pkg::NCELL + 1];
    ktau_pkg::tok_t tok;

    // Number of eight-entry blocks that hold stored pairs.
    assign nblk     = ktau_pkg::BLK_W'((cnt_reg + ktau_pkg::CNT_W'(ktau_pkg::NCELL - 1))
                                       >> ktau_pkg::CELL_W);
    assign mag      = sum_reg[ktau_pkg::SUM_W-1] ? ktau_pkg::MAG_W'(-sum_reg)
                                                 : sum_reg[ktau_pkg::MAG_W-1:0];
    assign trivial  = den_reg == '0 || s2_reg == '0;
    assign emit     = !out_valid_reg || m_tready;
    assign coll_out = link[ktau_pkg::NCELL].valid
                      && link[ktau_pkg::NCELL].kind == ktau_pkg::TK_COLL;
    // Largest odd o with o*o <= quotient is root or root-1; q = (o + 1) / 2.
    assign qmag     = ktau_pkg::TAU_W'(({1'b0, root} + 19'd1) >> 1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ktau_pkg::ST_IDLE:
                if (s_tvalid)
                begin
                    if (cnt_reg == ktau_pkg::CNT_W'(ktau_pkg::MAX_N))
                        state_next = s_tlast ? ktau_pkg::ST_COLLECT : ktau_pkg::ST_IDLE;
                    else if (cnt_reg == '0)
                        state_next = ktau_pkg::ST_WRITE;
                    else
                        state_next = ktau_pkg::ST_SWEEP;
                end
            ktau_pkg::ST_SWEEP:
                if (ktau_pkg::BLK_W'(addr_reg) == nblk - ktau_pkg::BLK_W'(1))
                    state_next = ktau_pkg::ST_WRITE;
            ktau_pkg::ST_WRITE:
                state_next = last_reg ? ktau_pkg::ST_COLLECT : ktau_pkg::ST_IDLE;
            ktau_pkg::ST_COLLECT:
                state_next = ktau_pkg::ST_WAIT;
            ktau_pkg::ST_WAIT:
                if (coll_out)
                    state_next = ktau_pkg::ST_MUL;
            ktau_pkg::ST_MUL:
                state_next = ktau_pkg::ST_TEST;
            ktau_pkg::ST_TEST:
                state_next = trivial ? ktau_pkg::ST_DONE : ktau_pkg::ST_DIV;
            ktau_pkg::ST_DIV:
                if (div_done)
                    state_next = ktau_pkg::ST_SQRT;
            ktau_pkg::ST_SQRT:
                if (sq_done)
                    state_next = ktau_pkg::ST_DONE;
            ktau_pkg::ST_DONE:
                if (emit)
                    state_next = ktau_pkg::ST_IDLE;
            default:
                state_next = ktau_pkg::ST_IDLE;
        endcase
    end

    // State outputs: handshake, chain token and unit starts.
    always_comb
    begin
        s_tready  = state_reg == ktau_pkg::ST_IDLE;
        div_start = state_reg == ktau_pkg::ST_TEST && !trivial;
        sq_start  = state_reg == ktau_pkg::ST_DIV && div_done;
        tok       = '0;
        tok.x     = xk_reg;
        tok.y     = yk_reg;
        tok.addr  = addr_reg;
        tok.cnt   = cnt_reg;
        case (state_reg)
            ktau_pkg::ST_SWEEP:
            begin
                tok.valid = 1'b1;
                tok.kind  = ktau_pkg::TK_CMP;
            end
            ktau_pkg::ST_WRITE:
            begin
                tok.valid = 1'b1;
                tok.kind  = ktau_pkg::TK_WR;
            end
            ktau_pkg::ST_COLLECT:
            begin
                tok.valid = 1'b1;
                tok.kind  = ktau_pkg::TK_COLL;
            end
            default:
                tok.valid = 1'b0;
        endcase
    end

    assign link[0] = tok;

    for (genvar c = 0; c < ktau_pkg::NCELL; c++)
    begin : g_cell
        ktau_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cell_id (ktau_pkg::CELL_W'(c)),
            .tok_in  (link[c]),
            .tok_out (link[c + 1])
        );
    end

    ktau_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (s2_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (quo)
    );

    ktau_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .rad   (quo),
        .done  (sq_done),
        .root  (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ktau_pkg::ST_IDLE;
            cnt_reg       <= '0;
            addr_reg      <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ktau_pkg::ST_DONE && emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ktau_pkg::ST_IDLE:
                begin
                    addr_reg <= '0;
                    if (s_tvalid && cnt_reg == ktau_pkg::CNT_W'(ktau_pkg::MAX_N))
                        drop_reg <= 1'b1;
                end
                ktau_pkg::ST_SWEEP:
                    addr_reg <= addr_reg + ktau_pkg::ADDR_W'(1);
                ktau_pkg::ST_WRITE:
                    cnt_reg <= cnt_reg + ktau_pkg::CNT_W'(1);
                ktau_pkg::ST_DONE:
                    if (emit)
                    begin
                        cnt_reg  <= '0;
                        drop_reg <= 1'b0;
                    end
                default:
                    addr_reg <= addr_reg;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ktau_pkg::ST_IDLE && s_tvalid)
        begin
            // Flipping the sign bit makes unsigned order match signed order.
            xk_reg   <= s_tdata[31:0] ^ 32'h8000_0000;
            yk_reg   <= s_tdata[63:32] ^ 32'h8000_0000;
            last_reg <= s_tlast;
        end
        if (state_reg == ktau_pkg::ST_WAIT && coll_out)
        begin
            sum_reg <= link[ktau_pkg::NCELL].sum;
            cx_reg  <= link[ktau_pkg::NCELL].cx;
            cy_reg  <= link[ktau_pkg::NCELL].cy;
        end
        if (state_reg == ktau_pkg::ST_MUL)
        begin
            s2_reg  <= mag * mag;
            den_reg <= cx_reg * cy_reg;
        end
        if (div_done)
            quo_reg <= quo;
        if (state_reg == ktau_pkg::ST_DONE && emit)
        begin
            degen_reg <= den_reg == '0;
            ovf_reg   <= drop_reg;
            if (trivial)
                tau_reg <= '0;
            else
                tau_reg <= sum_reg[ktau_pkg::SUM_W-1] ? ktau_pkg::TAU_W'(-qmag) : qmag;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, tau_reg};
    assign m_tuser  = {ovf_reg, degen_reg};

`ifndef SYNTHESIS
    // A pair that is stored always takes the block out of the idle state;
    // pairs dropped on a full store may follow back to back.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && cnt_reg != ktau_pkg::CNT_W'(ktau_pkg::MAX_N)
        |=> !s_tready)
        else $error("input accepted twice in a row");

    // Since |S| never exceeds sqrt(Cx*Cy), the quotient stays within 2^(2F+2).
    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        $past(div_done) |-> quo_reg <= ktau_pkg::QUO_W'(1) << (2 * ktau_pkg::FRAC + 2))
        else $error("quotient out of range");

    // The stored pair count never exceeds the capacity.
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= ktau_pkg::CNT_W'(ktau_pkg::MAX_N))
        else $error("pair count beyond capacity");
`endif

endmodule

@@ hdl/ktau_cell.sv @@
// One cell of the comparison chain: owns one bank of stored pairs and keeps
// partial concordance and non-tie counts for the entries in that bank.
module ktau_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ktau_pkg::CELL_W-1:0] cell_id,
    input  ktau_pkg::tok_t              tok_in,
    output ktau_pkg::tok_t              tok_out
);

    logic [ktau_pkg::KEY_W-1:0] xbank [ktau_pkg::BANK_DEPTH];
    logic [ktau_pkg::KEY_W-1:0] ybank [ktau_pkg::BANK_DEPTH];
    logic [ktau_pkg::KEY_W-1:0] rd_x_reg;
    logic [ktau_pkg::KEY_W-1:0] rd_y_reg;

    ktau_pkg::tok_t a_reg;
    ktau_pkg::tok_t b_reg;
    ktau_pkg::tok_t b_next;

    logic signed [ktau_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [ktau_pkg::NT_W-1:0]         cx_reg, cx_next;
    logic [ktau_pkg::NT_W-1:0]         cy_reg, cy_next;

    logic [ktau_pkg::CNT_W-1:0] idx;
    logic hit, xgt, xlt, ygt, ylt, is_coll;

    // Bank write and registered read.
    always_ff @(posedge clk)
    begin
        if (tok_in.valid)
        begin
            if (tok_in.kind == ktau_pkg::TK_WR
                && tok_in.cnt[ktau_pkg::CELL_W-1:0] == cell_id)
            begin
                xbank[tok_in.cnt[ktau_pkg::CNT_W-2:ktau_pkg::CELL_W]] <= tok_in.x;
                ybank[tok_in.cnt[ktau_pkg::CNT_W-2:ktau_pkg::CELL_W]] <= tok_in.y;
            end
            rd_x_reg <= xbank[tok_in.addr];
            rd_y_reg <= ybank[tok_in.addr];
        end
    end

    always_comb
    begin
        idx     = {1'b0, a_reg.addr, cell_id};
        is_coll = a_reg.valid && a_reg.kind == ktau_pkg::TK_COLL;
        hit     = a_reg.valid && a_reg.kind == ktau_pkg::TK_CMP && idx < a_reg.cnt;
        xgt     = a_reg.x > rd_x_reg;
        xlt     = a_reg.x < rd_x_reg;
        ygt     = a_reg.y > rd_y_reg;
        ylt     = a_reg.y < rd_y_reg;

        sum_next = sum_reg;
        cx_next  = cx_reg;
        cy_next  = cy_reg;
        if (is_coll)
        begin
            sum_next = '0;
            cx_next  = '0;
            cy_next  = '0;
        end
        else if (hit)
        begin
            if ((xgt && ygt) || (xlt && ylt))
                sum_next = sum_reg + ktau_pkg::SUM_W'(1);
            else if ((xgt && ylt) || (xlt && ygt))
                sum_next = sum_reg - ktau_pkg::SUM_W'(1);
            if (xgt || xlt)
                cx_next = cx_reg + ktau_pkg::NT_W'(1);
            if (ygt || ylt)
                cy_next = cy_reg + ktau_pkg::NT_W'(1);
        end

        b_next = a_reg;
        if (is_coll)
        begin
            b_next.sum = a_reg.sum + sum_reg;
            b_next.cx  = a_reg.cx + cx_reg;
            b_next.cy  = a_reg.cy + cy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg   <= '0;
            b_reg   <= '0;
            sum_reg <= '0;
            cx_reg  <= '0;
            cy_reg  <= '0;
        end
        else
        begin
            a_reg   <= tok_in;
            b_reg   <= b_next;
            sum_reg <= sum_next;
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
        end
    end

    assign tok_out = b_reg;

endmodule

@@ hdl/ktau_div.sv @@
// Restoring divider, one quotient bit per cycle: (num << 2F+2) / den.
module ktau_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ktau_pkg::DEN_W-1:0] num,
    input  logic [ktau_pkg::DEN_W-1:0] den,
    output logic                       done,
    output logic [ktau_pkg::QUO_W-1:0] quo
);

    logic [ktau_pkg::NUM_BITS-1:0]  num_reg;
    logic [ktau_pkg::DEN_W-1:0]     den_reg;
    logic [ktau_pkg::DEN_W-1:0]     rem_reg;
    logic [ktau_pkg::QUO_W-1:0]     quo_reg;
    logic [ktau_pkg::NUM_CNT_W-1:0] cnt_reg;
    logic                           busy_reg, done_reg;
    logic [ktau_pkg::DEN_W:0]       rem_sh;
    logic                           ge;

    always_comb
    begin
        rem_sh = {rem_reg, num_reg[ktau_pkg::NUM_BITS-1]};
        ge     = rem_sh >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg
                        && cnt_reg == ktau_pkg::NUM_CNT_W'(ktau_pkg::NUM_BITS - 1);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + ktau_pkg::NUM_CNT_W'(1);
                if (cnt_reg == ktau_pkg::NUM_CNT_W'(ktau_pkg::NUM_BITS - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {num, {(ktau_pkg::NUM_BITS - ktau_pkg::DEN_W){1'b0}}};
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[ktau_pkg::NUM_BITS-2:0], 1'b0};
            rem_reg <= ge ? ktau_pkg::DEN_W'(rem_sh - {1'b0, den_reg})
                          : rem_sh[ktau_pkg::DEN_W-1:0];
            quo_reg <= {quo_reg[ktau_pkg::QUO_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

@@ hdl/ktau_isqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
module ktau_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ktau_pkg::QUO_W-1:0]  rad,
    output logic                        done,
    output logic [ktau_pkg::ROOT_W-1:0] root
);

    logic [ktau_pkg::RAD_W-1:0]    rad_reg;
    logic [ktau_pkg::SREM_W-1:0]   rem_reg;
    logic [ktau_pkg::ROOT_W-1:0]   root_reg;
    logic [ktau_pkg::SQ_CNT_W-1:0] cnt_reg;
    logic                          busy_reg, done_reg;
    logic [ktau_pkg::SREM_W-1:0]   rem_sh, trial;
    logic                          ge;

    always_comb
    begin
        rem_sh = {rem_reg[ktau_pkg::SREM_W-3:0], rad_reg[ktau_pkg::RAD_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg
                        && cnt_reg == ktau_pkg::SQ_CNT_W'(ktau_pkg::ROOT_W - 1);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + ktau_pkg::SQ_CNT_W'(1);
                if (cnt_reg == ktau_pkg::SQ_CNT_W'(ktau_pkg::ROOT_W - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= ktau_pkg::RAD_W'(rad);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[ktau_pkg::RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[ktau_pkg::ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ dv/testbench.sv @@
module testbench;

    // One pair as the sender offers it. A drain entry offers nothing: the sender
    // holds there until every expected tau result has come back.
    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               last;
        logic               drain;
    } pair_item_t;

    // One tau result as the block should report it.
    typedef struct {
        logic [17:0] tau;
        logic        degen;
        logic        ovf;
    } tau_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    pair_item_t  pending_pairs[$];
    tau_result_t expected_taus[$];

    // Shadow of the block's set state.
    logic signed [31:0] x_keys[ktau_pkg::MAX_N];
    logic signed [31:0] y_keys[ktau_pkg::MAX_N];
    int          stored_pairs;
    longint      concord_sum;
    longint      x_nontie;
    longint      y_nontie;
    bit          pairs_dropped;

    pair_item_t  offered;
    bit          pair_taken;
    int          send_gap;
    int          sent_count;
    int          recv_wait;
    int          taus_seen;
    int          fail_count;

    kendall_tau_b_correlation DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    // Rounded tau in Q16: the largest q with (2q-1)^2 * Cx*Cy <= 4 * S^2 * 2^32,
    // which is round-half-away-from-zero of |S| * 2^16 / sqrt(Cx * Cy).
    function automatic logic [17:0] rounded_tau(longint s, longint cx, longint cy);
        logic [127:0] den;
        logic [127:0] rhs;
        logic [127:0] odd;
        logic [127:0] lo;
        logic [127:0] hi;
        logic [127:0] mid;
        logic [127:0] mag;
        logic [17:0]  q;
        den = 128'(cx) * 128'(cy);
        mag = (s < 0) ? 128'(-s) : 128'(s);
        rhs = (mag * mag) << 34;
        lo = 0;
        hi = 128'd65536;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            odd = 2 * mid - 1;
            if (odd * odd * den <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        q = lo[17:0];
        return (s < 0) ? (18'd0 - q) : q;
    endfunction

    // Applies one accepted pair to the shadow state, and on the last pair of a
    // set queues the expected result and clears the set.
    task automatic absorb_pair(pair_item_t p);
        int          i;
        int          sx;
        int          sy;
        tau_result_t r;
        if (stored_pairs < ktau_pkg::MAX_N)
        begin
            for (i = 0; i < stored_pairs; i++)
            begin
                sx = (p.x > x_keys[i]) - (p.x < x_keys[i]);
                sy = (p.y > y_keys[i]) - (p.y < y_keys[i]);
                concord_sum += sx * sy;
                if (sx != 0) x_nontie++;
                if (sy != 0) y_nontie++;
            end
            x_keys[stored_pairs] = p.x;
            y_keys[stored_pairs] = p.y;
            stored_pairs++;
        end
        else
            pairs_dropped = 1;
        if (p.last)
        begin
            r.degen = (x_nontie * y_nontie == 0);
            r.tau   = r.degen ? 18'd0 : rounded_tau(concord_sum, x_nontie, y_nontie);
            r.ovf   = pairs_dropped;
            expected_taus.push_back(r);
            stored_pairs  = 0;
            concord_sum   = 0;
            x_nontie      = 0;
            y_nontie      = 0;
            pairs_dropped = 0;
        end
    endtask

    task automatic add_pair(logic signed [31:0] x, logic signed [31:0] y, bit last);
        pair_item_t p;
        p.x = x;
        p.y = y;
        p.last = last;
        p.drain = 0;
        pending_pairs.push_back(p);
    endtask

    task automatic add_drain();
        pair_item_t p;
        p.x = 0;
        p.y = 0;
        p.last = 0;
        p.drain = 1;
        pending_pairs.push_back(p);
    endtask

    // Draws a key: full range for bit coverage, or a narrow range to make ties.
    function automatic logic signed [31:0] draw_key(bit narrow);
        if (narrow)
            return $signed($urandom_range(0, 6)) - 3;
        return $urandom;
    endfunction

    // A random set of n pairs; a fraction are monotone to reach tau near +-1.
    task automatic add_random_set(int n);
        int  i;
        int  shape;
        bit  narrow;
        logic signed [31:0] x;
        shape = $urandom_range(0, 5);
        narrow = $urandom_range(0, 1);
        for (i = 0; i < n; i++)
        begin
            x = draw_key(narrow);
            if (shape == 0)
                add_pair(x, x, i == n - 1);
            else if (shape == 1)
                add_pair(x, ~x, i == n - 1);
            else
                add_pair(x, draw_key(narrow), i == n - 1);
        end
    endtask

    // Input acceptance and result checking, both at the rising edge.
    always @(posedge clk)
    begin
        tau_result_t e;
        if (rst_n && s_tvalid && s_tready)
        begin
            absorb_pair(offered);
            pair_taken = 1;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            taus_seen++;
            // One long hold-off early on lets the block fill up and stall input.
            recv_wait = (taus_seen == 3) ? 600 :
                        ((taus_seen % 40) < 10) ? 0 : $urandom_range(0, 17);
            if (expected_taus.size() == 0)
            begin
                $error("unexpected tau transaction tau_value=%0h", m_tdata[17:0]);
                fail_count++;
            end
            else
            begin
                e = expected_taus.pop_front();
                if (m_tdata[17:0] !== e.tau)
                begin
                    $error("tau_value expected %0h actual %0h", e.tau, m_tdata[17:0]);
                    fail_count++;
                end
                if (m_tuser[0] !== e.degen)
                begin
                    $error("degenerate expected %0b actual %0b", e.degen, m_tuser[0]);
                    fail_count++;
                end
                if (m_tuser[1] !== e.ovf)
                begin
                    $error("overflow expected %0b actual %0b", e.ovf, m_tuser[1]);
                    fail_count++;
                end
            end
        end
    end

    // Pair driver: changes inputs at the falling edge, one assignment per signal.
    always @(negedge clk)
    begin
        bit next_valid;
        pair_item_t p;
        if (rst_n)
        begin
            next_valid = s_tvalid;
            if (pair_taken)
            begin
                pair_taken = 0;
                next_valid = 0;
                sent_count++;
                send_gap = ((sent_count % 64) < 16) ? 0 : $urandom_range(0, 17);
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_pairs.size() > 0)
                begin
                    if (pending_pairs[0].drain)
                    begin
                        if (expected_taus.size() == 0)
                            void'(pending_pairs.pop_front());
                    end
                    else
                    begin
                        p = pending_pairs.pop_front();
                        offered = p;
                        s_tdata <= {p.y, p.x};
                        s_tlast <= p.last;
                        next_valid = 1;
                    end
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // Result receiver: holds m_tready low for the drawn number of cycles.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (recv_wait > 0)
            begin
                recv_wait--;
                m_tready <= 0;
            end
            else
                m_tready <= 1;
        end
    end

    initial
    begin
        int i;
        int base;
        clk = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tlast = 0;
        m_tready = 0;
        stored_pairs = 0;
        concord_sum = 0;
        x_nontie = 0;
        y_nontie = 0;
        pairs_dropped = 0;
        pair_taken = 0;
        send_gap = 0;
        sent_count = 0;
        recv_wait = 0;
        taus_seen = 0;
        fail_count = 0;

        // Directed sets: a single pair is degenerate.
        add_pair(32'sh7FFFFFFF, 32'sh80000000, 1);
        // All x tied: degenerate.
        add_pair(5, 1, 0);
        add_pair(5, 2, 0);
        add_pair(5, 3, 1);
        // Perfect concordance at the key extremes gives +1.0.
        add_pair(32'sh80000000, 32'sh80000000, 0);
        add_pair(0, -1, 0);
        add_pair(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1);
        // Perfect discordance gives -1.0.
        add_pair(32'sh80000000, 32'sh7FFFFFFF, 0);
        add_pair(-1, 0, 0);
        add_pair(32'sh7FFFFFFF, 32'sh80000000, 1);
        // Mixed ties, sum of two.
        add_pair(1, 1, 0);
        add_pair(2, 2, 0);
        add_pair(3, 1, 0);
        add_pair(4, 2, 1);
        // Partial ties in both variables.
        add_pair(1, 1, 0);
        add_pair(1, 2, 0);
        add_pair(2, 2, 0);
        add_pair(3, 3, 1);
        add_drain();

        // A full store: pairs past capacity are dropped, the last one included.
        for (i = 0; i < ktau_pkg::MAX_N + 2; i++)
            add_pair($urandom, $urandom, i == ktau_pkg::MAX_N + 1);
        add_drain();

        // Random sets, mostly small.
        base = pending_pairs.size();
        while (pending_pairs.size() < base + 400)
        begin
            add_random_set(($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) :
                                                        $urandom_range(1, 8));
            if ($urandom_range(0, 15) == 0)
                add_drain();
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        wait (pending_pairs.size() == 0 && !s_tvalid);
        wait (expected_taus.size() == 0);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule
